>>> src/lpld_pkg.sv
// Package with shared types and codes for the layer-partitioned LRU directory.
`timescale 1ns / 1ps
package lpld_pkg;

    localparam int SLOT_CAPACITY = 1024;
    localparam int MAX_LAYERS    = 64;
    localparam int MAX_EXPERTS   = 256;

    typedef enum logic [1:0] {
        KIND_LOOKUP   = 2'd0,
        KIND_ALLOCATE = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_EXPERTS = 2'd0,
        REG_LAYERS  = 2'd1,
        REG_SLOTS   = 2'd2,
        REG_NONE    = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIR_READ,
        ST_DIR_WAIT,
        ST_LOOKUP_DONE,
        ST_SCAN_START,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_OWNER_READ,
        ST_OWNER_WAIT,
        ST_EVICT,
        ST_INSTALL,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] layer;
        logic [7:0] expert;
    } req_t;

    typedef struct packed {
        logic [9:0]  slot;
        logic        found;
        logic        error;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } rsp_t;

endpackage

>>> src/lpld_stream_if.sv
// Valid/ready stream interface carrying one payload.
`timescale 1ns / 1ps
interface lpld_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/lpld_regs.sv
// APB configuration registers of the directory.
`timescale 1ns / 1ps
module lpld_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [8:0]  experts_in_use,
    output logic [6:0]  layers_in_use,
    output logic [10:0] slots_per_partition
);
    import lpld_pkg::*;

    logic [8:0]  experts_reg;
    logic [6:0]  layers_reg;
    logic [10:0] slots_reg;
    logic [1:0]  index;
    logic        wr_en;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            experts_reg <= 9'd256;
            layers_reg  <= 7'd64;
            slots_reg   <= 11'd16;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(index))
                REG_EXPERTS: experts_reg <= pwdata[8:0];
                REG_LAYERS:  layers_reg  <= pwdata[6:0];
                REG_SLOTS:   slots_reg   <= pwdata[10:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(index))
            REG_EXPERTS: prdata = {23'd0, experts_reg};
            REG_LAYERS:  prdata = {25'd0, layers_reg};
            REG_SLOTS:   prdata = {21'd0, slots_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign experts_in_use      = experts_reg;
    assign layers_in_use       = layers_reg;
    assign slots_per_partition = slots_reg;
endmodule

>>> src/layer_partitioned_lru_directory.sv
// Top level: layer-partitioned LRU slot directory for (layer, expert) pairs.
// A lookup passes ST_DIR_READ, ST_DIR_WAIT and ST_LOOKUP_DONE before ST_OUTPUT; an allocate
// scans its partition in the stamp memory one stamp per cycle, then evicts the owner and installs.
// Clear, unused kinds and flagged requests go straight to ST_OUTPUT. One item is in flight at a time;
// a new item is taken the cycle after the result transfer.
// After reset a clearing pass empties both memories before the first transfer.
`timescale 1ns / 1ps
module layer_partitioned_lru_directory (
    input  logic                 clk,
    input  logic                 rst_n,
    lpld_stream_if.sink          req,
    lpld_stream_if.source        rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import lpld_pkg::*;

    localparam int DIR_DEPTH = MAX_LAYERS * MAX_EXPERTS;
    localparam int DW = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
    localparam int SW = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int CLR_N = (DIR_DEPTH > SLOT_CAPACITY) ? DIR_DEPTH : SLOT_CAPACITY;
    localparam int CW = $clog2(CLR_N + 1);
    localparam int SLOT_W = 11;
    localparam int LW = 7;
    localparam int EW = 9;

    logic [8:0]  experts_in_use;
    logic [6:0]  layers_in_use;
    logic [10:0] slots_per_partition;

    lpld_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .experts_in_use, .layers_in_use, .slots_per_partition
    );

    // Directory memory: mapped bit plus slot.
    logic [SLOT_W:0] dir_mem [DIR_DEPTH];
    logic            dir_we;
    logic [DW-1:0]   dir_waddr, dir_raddr;
    logic [SLOT_W:0] dir_wdata, dir_rdata;

    always_ff @(posedge clk)
    begin
        if (dir_we)
            dir_mem[dir_waddr] <= dir_wdata;
        dir_rdata <= dir_mem[dir_raddr];
    end

    // Slot memory: owner valid, owner layer, owner expert, stamp.
    localparam int OW = 1 + LW + EW;
    logic [OW+63:0] slot_mem [SLOT_CAPACITY];
    logic           slot_we;
    logic [SW-1:0]  slot_waddr, slot_raddr;
    logic [OW+63:0] slot_wdata, slot_rdata;

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rdata <= slot_mem[slot_raddr];
    end

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [63:0] clock_reg, clock_next;
    logic [31:0] hit_reg, hit_next, miss_reg, miss_next;
    logic [16:0] scan_reg, scan_next;
    logic [16:0] best_reg, best_next;
    logic [63:0] best_ts_reg, best_ts_next;
    logic [16:0] base_reg, base_next;
    logic [16:0] end_reg, end_next;
    logic [DW-1:0] idx_reg, idx_next;
    logic        bad_reg, bad_next;
    logic [16:0] hit_slot_reg, hit_slot_next;
    logic        found_reg, found_next;
    logic        err_reg, err_next;
    logic [OW-1:0] owner_reg, owner_next;
    rsp_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic [8:0]  stride;
    logic [21:0] idx_calc;
    logic [21:0] oidx_calc;
    logic        bad_calc;
    logic [17:0] part_calc;
    logic [16:0] base_calc;
    logic [63:0] clock_inc;

    assign stride = (experts_in_use > 9'(MAX_EXPERTS)) ? 9'(MAX_EXPERTS) : experts_in_use;
    assign clock_inc = clock_reg + 64'd1;

    always_comb
    begin
        idx_calc = 22'(req.data.layer) * 22'(stride) + 22'(req.data.expert);
        bad_calc = (7'(req.data.layer) >= layers_in_use)
            || (32'(req.data.layer) >= 32'(MAX_LAYERS))
            || (9'(req.data.expert) >= experts_in_use)
            || (32'(req.data.expert) >= 32'(MAX_EXPERTS))
            || (32'(idx_calc) >= 32'(DIR_DEPTH));
        part_calc = 18'(req.data.layer + 7'd1) * 18'(slots_per_partition);
        base_calc = 17'(18'(req.data.layer) * 18'(slots_per_partition));
        if (req.data.kind == KIND_ALLOCATE && !bad_calc)
            bad_calc = (slots_per_partition == 11'd0) || (32'(part_calc) > 32'(SLOT_CAPACITY));
        oidx_calc = 22'(owner_reg[EW+LW-1:EW]) * 22'(stride) + 22'(owner_reg[EW-1:0]);
    end

    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            clock_reg     <= '0;
            hit_reg       <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clock_reg     <= clock_next;
            hit_reg       <= hit_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        scan_reg     <= scan_next;
        best_reg     <= best_next;
        best_ts_reg  <= best_ts_next;
        base_reg     <= base_next;
        end_reg      <= end_next;
        idx_reg      <= idx_next;
        bad_reg      <= bad_next;
        hit_slot_reg <= hit_slot_next;
        found_reg    <= found_next;
        err_reg      <= err_next;
        owner_reg    <= owner_next;
        out_reg      <= out_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (32'(clr_reg) == CLR_N - 1)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (req.valid && req.ready)
                begin
                    if ((req.data.kind == KIND_LOOKUP) && !bad_calc)
                        state_next = ST_DIR_READ;
                    else if ((req.data.kind == KIND_ALLOCATE) && !bad_calc)
                        state_next = ST_SCAN_START;
                    else
                        state_next = ST_OUTPUT;
                end
            ST_DIR_READ:    state_next = ST_DIR_WAIT;
            ST_DIR_WAIT:    state_next = ST_LOOKUP_DONE;
            ST_LOOKUP_DONE: state_next = ST_OUTPUT;
            ST_SCAN_START:  state_next = ST_SCAN;
            ST_SCAN:
                if (scan_reg == end_reg + 17'd1)
                    state_next = ST_OWNER_READ;
            ST_SCAN_LAST:   state_next = ST_OWNER_READ;
            ST_OWNER_READ:  state_next = ST_OWNER_WAIT;
            ST_OWNER_WAIT:  state_next = ST_EVICT;
            ST_EVICT:       state_next = ST_INSTALL;
            ST_INSTALL:     state_next = ST_OUTPUT;
            ST_OUTPUT:      state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        req_next       = req_reg;
        clr_next       = clr_reg;
        clock_next     = clock_reg;
        hit_next       = hit_reg;
        miss_next      = miss_reg;
        scan_next      = scan_reg;
        best_next      = best_reg;
        best_ts_next   = best_ts_reg;
        base_next      = base_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        bad_next       = bad_reg;
        hit_slot_next  = hit_slot_reg;
        found_next     = found_reg;
        err_next       = err_reg;
        owner_next     = owner_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        dir_we     = 1'b0;
        dir_waddr  = '0;
        dir_wdata  = '0;
        dir_raddr  = idx_reg;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_raddr = scan_reg[SW-1:0];

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                if (32'(clr_reg) < DIR_DEPTH)
                begin
                    dir_we    = 1'b1;
                    dir_waddr = clr_reg[DW-1:0];
                end
                if (32'(clr_reg) < SLOT_CAPACITY)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = clr_reg[SW-1:0];
                end
                clr_next = clr_reg + CW'(1);
            end
            ST_IDLE:
                if (req.valid && req.ready)
                begin
                    req_next      = req.data;
                    idx_next      = idx_calc[DW-1:0];
                    bad_next      = bad_calc;
                    base_next     = base_calc;
                    end_next      = base_calc + 17'(slots_per_partition) - 17'd1;
                    scan_next     = base_calc;
                    hit_slot_next = '0;
                    found_next    = 1'b0;
                    err_next      = (req.data.kind == KIND_LOOKUP
                                    || req.data.kind == KIND_ALLOCATE) && bad_calc;
                    if (req.data.kind == KIND_CLEAR)
                    begin
                        hit_next  = '0;
                        miss_next = '0;
                    end
                end
            ST_DIR_READ:
                dir_raddr = idx_reg;
            ST_DIR_WAIT:
                ;
            ST_LOOKUP_DONE:
            begin
                if (dir_rdata[SLOT_W] && (32'(dir_rdata[SLOT_W-1:0]) < SLOT_CAPACITY))
                begin
                    hit_slot_next = 17'(dir_rdata[SLOT_W-1:0]);
                    found_next    = 1'b1;
                    clock_next    = clock_inc;
                    slot_raddr    = dir_rdata[SW-1:0];
                    if (hit_reg != 32'hFFFF_FFFF)
                        hit_next = hit_reg + 32'd1;
                end
                else if (miss_reg != 32'hFFFF_FFFF)
                    miss_next = miss_reg + 32'd1;
            end
            ST_SCAN_START:
            begin
                slot_raddr = scan_reg[SW-1:0];
                scan_next  = scan_reg + 17'd1;
                best_next  = base_reg;
                best_ts_next = '1;
            end
            ST_SCAN, ST_SCAN_LAST:
            begin
                // slot_rdata holds the stamp of slot scan_reg - 1.
                slot_raddr = scan_reg[SW-1:0];
                scan_next  = scan_reg + 17'd1;
                if ((scan_reg - 17'd1 == base_reg) || (slot_rdata[63:0] < best_ts_reg))
                begin
                    best_ts_next = slot_rdata[63:0];
                    best_next    = scan_reg - 17'd1;
                end
            end
            ST_OWNER_READ:
                slot_raddr = best_reg[SW-1:0];
            ST_OWNER_WAIT:
                owner_next = slot_rdata[OW+63:64];
            ST_EVICT:
            begin
                if (owner_reg[OW-1] && (32'(oidx_calc) < DIR_DEPTH))
                begin
                    dir_we    = 1'b1;
                    dir_waddr = oidx_calc[DW-1:0];
                end
            end
            ST_INSTALL:
            begin
                dir_we     = 1'b1;
                dir_waddr  = idx_reg;
                dir_wdata  = {1'b1, SLOT_W'(best_reg)};
                slot_we    = 1'b1;
                slot_waddr = best_reg[SW-1:0];
                slot_wdata = {1'b1, LW'(req_reg.layer), EW'(req_reg.expert), clock_inc};
                clock_next = clock_inc;
                hit_slot_next = best_reg;
            end
            ST_OUTPUT:
            begin
                out_next.slot       = hit_slot_reg[9:0];
                out_next.found      = found_reg;
                out_next.error      = err_reg;
                out_next.hit_total  = hit_reg;
                out_next.miss_total = miss_reg;
                out_valid_next      = 1'b1;
            end
            default:
                ;
        endcase

        // Lookup hit stamps the slot; owner fields are kept via read-modify-write.
        if (state_reg == ST_OUTPUT && found_reg)
        begin
            slot_we    = 1'b1;
            slot_waddr = hit_slot_reg[SW-1:0];
            slot_wdata = {slot_rdata[OW+63:64], clock_reg};
        end
    end

    property p_ready_only_idle;
        @(posedge clk) disable iff (!rst_n) req.ready |-> !out_valid_reg;
    endproperty
    assert property (p_ready_only_idle) else $error("ready while result pending");

    property p_out_after_output;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_OUTPUT) |=> out_valid_reg;
    endproperty
    assert property (p_out_after_output) else $error("result not loaded");

    property p_found_no_error;
        @(posedge clk) disable iff (!rst_n) out_valid_reg |-> !(out_reg.found && out_reg.error);
    endproperty
    assert property (p_found_no_error) else $error("found and error together");

    property p_clock_step;
        @(posedge clk) disable iff (!rst_n)
            (state_reg != ST_CLEAR) |=> (clock_reg == $past(clock_reg))
                || (clock_reg == $past(clock_reg) + 64'd1);
    endproperty
    assert property (p_clock_step) else $error("use clock jumped");
endmodule
